@@ sv/cpr_pkg.sv @@
// constants and codes shared by the chunked packet reassembler
package cpr_pkg;

    localparam int MAX_PACKET_BYTES = 255;
    localparam int QUEUE_DEPTH      = 8;

    // packet slots in the byte store: queued packets plus assembly and spare
    localparam int NSLOT = QUEUE_DEPTH + 2;
    localparam int SLW   = $clog2(NSLOT);
    localparam int HW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW    = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH = NSLOT * 256;
    localparam int MAW       = SLW + 8;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic [2:0] ST_CHUNK_OK  = 3'd0;
    localparam logic [2:0] ST_QUEUED    = 3'd1;
    localparam logic [2:0] ST_FULL_DROP = 3'd2;
    localparam logic [2:0] ST_IGNORED   = 3'd3;
    localparam logic [2:0] ST_BAD_LEN   = 3'd4;
    localparam logic [2:0] ST_ORDER     = 3'd5;
    localparam logic [2:0] ST_EMPTY     = 3'd6;
    localparam logic [2:0] ST_OVERSIZE  = 3'd7;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_DATA   = 1'b1;

    localparam logic REG_FRAME_MAGIC = 1'b0;

endpackage

@@ sv/chunked_packet_reassembler.sv @@
// chunked packet reassembler: frame judging, packet queue and byte readout
//
// Input stream (s_*): one request per accepted beat. tuser carries the op:
// write one frame byte, read one packet byte, clear everything, or no-op.
// Write bytes form a frame (4 header bytes: magic, id, total, offset, then a
// chunk); tlast marks the frame's final byte, which yields one status result.
// A read yields one result: a packet byte, an empty status or an oversize drop.
// Chunk bytes go straight into a synchronous byte store of packet slots, so
// no bytes are ever copied; the queue holds slot numbers and lengths.
// Throughput is one request per cycle while s_tready is high, set by the single
// write and single read port of the byte store. A result is registered first in
// the result stage, with the store read, then in the output register on m_*.
// The input side keeps taking requests while a result waits in the output
// register; it stalls only when both the result stage and the output
// register are full and m_tready is low.
// Reset (aresetn low, synchronous) empties the queue, drops any assembly and
// sets frame_magic to 0; the byte store needs no clearing pass.
// The APB port holds frame_magic at address 0; pready is always high.
module chunked_packet_reassembler
    import cpr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: data_byte[7:0], link_ok[8], read_capacity[16:9], zero[23:17]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        s_tlast,
    // s_tuser: op[1:0]
    input  logic [1:0]  s_tuser,
    // m_tdata: status[2:0], out_byte[10:3], packet_length[18:11],
    //          queue_count[22:19], zero[23]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    output logic        m_tlast,
    // m_tuser: kind[0]
    output logic [0:0]  m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // config
    logic [7:0] frame_magic_reg;

    // frame and assembly state
    logic [31:0]      hdr_reg, hdr_next;
    logic [8:0]       fbc_reg, fbc_next;
    logic             active_reg, active_next;
    logic [7:0]       aid_reg, aid_next;
    logic [7:0]       atot_reg, atot_next;
    logic [7:0]       arec_reg, arec_next;
    logic [SLW-1:0]   asm_slot_reg, asm_slot_next;
    logic [SLW-1:0]   spare_slot_reg, spare_slot_next;
    logic [NSLOT-1:0] free_reg, free_next;

    // queue state
    logic [HW-1:0]    head_reg, head_next;
    logic [FW-1:0]    fill_reg, fill_next;
    logic [7:0]       ridx_reg, ridx_next;
    logic [SLW-1:0]   ring_slot [0:QUEUE_DEPTH-1];
    logic [7:0]       ring_len  [0:QUEUE_DEPTH-1];

    // byte store
    logic [7:0]       mem [0:MEM_DEPTH-1];
    logic             mem_we, mem_re;
    logic [MAW-1:0]   mem_waddr, mem_raddr;
    logic [7:0]       rd_q_reg;

    // result stage and output register
    logic       p_valid_reg, p_valid_next;
    logic       p_kind_reg, p_last_reg, p_mem_reg;
    logic [2:0] p_status_reg;
    logic [7:0] p_plen_reg;
    logic [3:0] p_qc_reg;
    logic       o_valid_reg, o_kind_reg, o_last_reg;
    logic [2:0] o_status_reg;
    logic [7:0] o_byte_reg, o_plen_reg;
    logic [3:0] o_qc_reg;

    // request fields
    logic [1:0] in_op;
    logic [7:0] in_byte, in_cap;
    logic       in_link, in_last;
    logic       s_fire, p_move, cfg_we;

    // result of the current request
    logic       res_valid, res_kind, res_last, res_mem;
    logic [2:0] res_status;
    logic [7:0] res_plen;

    // frame work
    logic [31:0]    hdr_upd;
    logic [8:0]     cnt_upd, ci, chunk;
    logic [9:0]     wpos, chk_sum;
    logic           restart, ignored, bad_len, mismatch, done;
    logic [7:0]     h_id, h_tot, h_off, base_rec, base_tot, rec_new;
    logic [SLW-1:0] eff_slot, pick;
    logic           push;
    logic [FW:0]    tail_w;
    logic [HW-1:0]  tail, head_inc;
    logic [SLW-1:0] hslot;
    logic [7:0]     hlen;
    logic           fin;

    assign in_op   = s_tuser;
    assign in_byte = s_tdata[7:0];
    assign in_link = s_tdata[8];
    assign in_cap  = s_tdata[16:9];
    assign in_last = s_tlast;

    assign p_move   = p_valid_reg && (!o_valid_reg || m_tready);
    assign s_tready = !p_valid_reg || !o_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_FRAME_MAGIC) ? {24'd0, frame_magic_reg} : 32'd0;

    // lowest free slot
    always_comb begin
        pick = '0;
        for (int i = NSLOT - 1; i >= 0; i--) begin
            if (free_reg[i]) begin
                pick = SLW'(i);
            end
        end
    end

    assign tail_w   = ((FW+1)'(head_reg) + (FW+1)'(fill_reg) >= (FW+1)'(QUEUE_DEPTH)) ?
                      (FW+1)'(head_reg) + (FW+1)'(fill_reg) - (FW+1)'(QUEUE_DEPTH) :
                      (FW+1)'(head_reg) + (FW+1)'(fill_reg);
    assign tail     = tail_w[HW-1:0];
    assign head_inc = (head_reg == HW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign hslot    = ring_slot[head_reg];
    assign hlen     = ring_len[head_reg];

    always_comb begin
        hdr_upd = hdr_reg;
        if (fbc_reg < 9'd4) begin
            case (fbc_reg[1:0])
                2'd0:    hdr_upd[31:24] = in_byte;
                2'd1:    hdr_upd[23:16] = in_byte;
                2'd2:    hdr_upd[15:8]  = in_byte;
                default: hdr_upd[7:0]   = in_byte;
            endcase
        end
        cnt_upd = (fbc_reg == 9'd511) ? fbc_reg : fbc_reg + 9'd1;
        h_id    = hdr_upd[23:16];
        h_tot   = hdr_upd[15:8];
        h_off   = hdr_upd[7:0];
        ci      = fbc_reg - 9'd4;
        wpos    = {2'b00, hdr_reg[7:0]} + {1'b0, ci};
        // a new id starts in the spare slot so the live assembly survives a
        // frame that is later ignored
        restart = !active_reg || (aid_reg != h_id);
        chunk   = cnt_upd - 9'd4;
        chk_sum = {2'b00, h_off} + {1'b0, chunk};
        ignored = !in_link || (cnt_upd < 9'd4) || (hdr_upd[31:24] != frame_magic_reg);
        bad_len = (h_tot == 8'd0) || (9'(h_tot) > 9'(MAX_PACKET_BYTES)) ||
                  (chunk == 9'd0) || (chk_sum > {2'b00, h_tot});
        eff_slot = restart ? spare_slot_reg : asm_slot_reg;
        base_rec = restart ? 8'd0 : arec_reg;
        base_tot = restart ? h_tot : atot_reg;
        mismatch = (base_tot != h_tot) || (h_off != base_rec);
        rec_new  = base_rec + chunk[7:0];
        done     = !(rec_new < base_tot);
        fin      = ({1'b0, ridx_reg} + 9'd1) >= {1'b0, hlen};

        hdr_next        = hdr_reg;
        fbc_next        = fbc_reg;
        active_next     = active_reg;
        aid_next        = aid_reg;
        atot_next       = atot_reg;
        arec_next       = arec_reg;
        asm_slot_next   = asm_slot_reg;
        spare_slot_next = spare_slot_reg;
        free_next       = free_reg;
        head_next       = head_reg;
        fill_next       = fill_reg;
        ridx_next       = ridx_reg;
        push            = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = {eff_slot, wpos[7:0]};
        mem_re          = 1'b0;
        mem_raddr       = {hslot, ridx_reg};
        res_valid       = 1'b0;
        res_kind        = KIND_STATUS;
        res_status      = ST_CHUNK_OK;
        res_last        = 1'b0;
        res_plen        = 8'd0;
        res_mem         = 1'b0;

        if (s_fire) begin
            case (in_op)
                OP_WRITE: begin
                    hdr_next = hdr_upd;
                    // chunk bytes only land above the bytes already assembled
                    if (fbc_reg >= 9'd4 && !ci[8] && !wpos[9] && !wpos[8] &&
                        (restart || wpos[7:0] >= arec_reg)) begin
                        mem_we = 1'b1;
                    end
                    fbc_next = cnt_upd;
                    if (in_last) begin
                        fbc_next  = 9'd0;
                        res_valid = 1'b1;
                        if (ignored) begin
                            res_status = ST_IGNORED;
                        end else if (bad_len) begin
                            res_status  = ST_BAD_LEN;
                            active_next = 1'b0;
                        end else begin
                            if (restart) begin
                                aid_next        = h_id;
                                atot_next       = h_tot;
                                asm_slot_next   = spare_slot_reg;
                                spare_slot_next = asm_slot_reg;
                            end
                            arec_next = base_rec;
                            if (mismatch) begin
                                res_status  = ST_ORDER;
                                active_next = 1'b0;
                            end else begin
                                arec_next = rec_new;
                                if (!done) begin
                                    res_status  = ST_CHUNK_OK;
                                    active_next = 1'b1;
                                end else begin
                                    active_next = 1'b0;
                                    res_plen    = h_tot;
                                    if (fill_reg >= FW'(QUEUE_DEPTH)) begin
                                        res_status  = ST_FULL_DROP;
                                        if (restart) begin
                                            active_next = 1'b0;
                                        end
                                    end else begin
                                        res_status    = ST_QUEUED;
                                        push          = 1'b1;
                                        fill_next     = fill_reg + 1'b1;
                                        asm_slot_next = pick;
                                        free_next[pick] = 1'b0;
                                    end
                                end
                            end
                        end
                    end
                end
                OP_READ: begin
                    res_valid = 1'b1;
                    if (fill_reg == '0) begin
                        res_status = ST_EMPTY;
                    end else if (ridx_reg == 8'd0 && hlen > in_cap) begin
                        res_status      = ST_OVERSIZE;
                        res_plen        = hlen;
                        head_next       = head_inc;
                        fill_next       = fill_reg - 1'b1;
                        ridx_next       = 8'd0;
                        free_next[hslot] = 1'b1;
                    end else begin
                        mem_re   = 1'b1;
                        res_mem  = 1'b1;
                        res_kind = KIND_DATA;
                        res_last = fin;
                        res_plen = hlen;
                        if (fin) begin
                            head_next        = head_inc;
                            fill_next        = fill_reg - 1'b1;
                            ridx_next        = 8'd0;
                            free_next[hslot] = 1'b1;
                        end else begin
                            ridx_next = ridx_reg + 8'd1;
                        end
                    end
                end
                OP_CLEAR: begin
                    fill_next   = '0;
                    head_next   = '0;
                    ridx_next   = 8'd0;
                    active_next = 1'b0;
                    arec_next   = 8'd0;
                    fbc_next    = 9'd0;
                    free_next   = ~((NSLOT'(1) << asm_slot_reg) | (NSLOT'(1) << spare_slot_reg));
                end
                default: begin
                end
            endcase
        end

        p_valid_next = p_valid_reg;
        if (s_fire && res_valid) begin
            p_valid_next = 1'b1;
        end else if (p_move) begin
            p_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_magic_reg <= 8'd0;
            hdr_reg         <= 32'd0;
            fbc_reg         <= 9'd0;
            active_reg      <= 1'b0;
            aid_reg         <= 8'd0;
            atot_reg        <= 8'd0;
            arec_reg        <= 8'd0;
            asm_slot_reg    <= SLW'(0);
            spare_slot_reg  <= SLW'(1);
            free_reg        <= ~NSLOT'(3);
            head_reg        <= '0;
            fill_reg        <= '0;
            ridx_reg        <= 8'd0;
            p_valid_reg     <= 1'b0;
            o_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we && paddr[2] == REG_FRAME_MAGIC) begin
                frame_magic_reg <= pwdata[7:0];
            end
            hdr_reg        <= hdr_next;
            fbc_reg        <= fbc_next;
            active_reg     <= active_next;
            aid_reg        <= aid_next;
            atot_reg       <= atot_next;
            arec_reg       <= arec_next;
            asm_slot_reg   <= asm_slot_next;
            spare_slot_reg <= spare_slot_next;
            free_reg       <= free_next;
            head_reg       <= head_next;
            fill_reg       <= fill_next;
            ridx_reg       <= ridx_next;
            p_valid_reg    <= p_valid_next;
            if (p_move) begin
                o_valid_reg <= 1'b1;
            end else if (m_tready) begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (push) begin
            ring_slot[tail] <= eff_slot;
            ring_len[tail]  <= h_tot;
        end
        if (s_fire && res_valid) begin
            p_kind_reg   <= res_kind;
            p_status_reg <= res_status;
            p_last_reg   <= res_last;
            p_plen_reg   <= res_plen;
            p_qc_reg     <= 4'(fill_next);
            p_mem_reg    <= res_mem;
        end
        if (p_move) begin
            o_kind_reg   <= p_kind_reg;
            o_status_reg <= p_status_reg;
            o_last_reg   <= p_last_reg;
            o_plen_reg   <= p_plen_reg;
            o_qc_reg     <= p_qc_reg;
            o_byte_reg   <= p_mem_reg ? rd_q_reg : 8'd0;
        end
    end

    // byte store
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= in_byte;
        end
        if (mem_re) begin
            rd_q_reg <= mem[mem_raddr];
        end
    end

    assign m_tvalid   = o_valid_reg;
    assign m_tdata    = {1'b0, o_qc_reg, o_plen_reg, o_byte_reg, o_status_reg};
    assign m_tlast    = o_last_reg;
    assign m_tuser[0] = o_kind_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FW'(QUEUE_DEPTH))
        else $error("queue fill above depth");

    a_slots_distinct: assert property (@(posedge aclk) disable iff (!aresetn)
        asm_slot_reg != spare_slot_reg)
        else $error("assembly and spare slot coincide");

    a_slots_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        !free_reg[asm_slot_reg] && !free_reg[spare_slot_reg])
        else $error("assembly or spare slot marked free");

    a_free_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(free_reg) + int'(fill_reg) + 2 == NSLOT)
        else $error("slot accounting broken");

    a_active_partial: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (arec_reg < atot_reg))
        else $error("active assembly already complete");
`endif

endmodule

@@ bench/chunked_packet_reassembler_tb.sv @@
// self-checking testbench for the chunked packet reassembler
module chunked_packet_reassembler_tb
    import cpr_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 406;

    typedef struct packed {
        logic       kind;
        logic [2:0] status;
        logic [7:0] out_byte;
        logic       last;
        logic [7:0] plen;
        logic [3:0] qcount;
    } result_t;

    // tracks frame assembly and the packet queue, keeps the results still owed
    class packet_tracker;
        logic [7:0]  magic = 8'h00;
        logic [7:0]  asm_bytes [256];
        logic [7:0]  chunk_bytes [256];
        bit          asm_active = 0;
        logic [7:0]  asm_id = 8'h00;
        logic [7:0]  asm_total = 8'h00;
        int          asm_rcvd = 0;
        logic [31:0] hdr = 32'h0;
        int          frame_count = 0;
        logic [7:0]  pkt_bytes [QUEUE_DEPTH][256];
        int          pkt_len [QUEUE_DEPTH];
        int          head = 0;
        int          fill = 0;
        int          rd_idx = 0;
        result_t     pending_results [$];
        int          errors = 0;
        int          status_hits [8];
        int          data_hits = 0;

        function void pop_packet();
            head = (head + 1) % QUEUE_DEPTH;
            fill--;
            rd_idx = 0;
        endfunction

        function int head_length();
            return (fill == 0) ? 0 : pkt_len[head];
        endfunction

        function void take_request(logic [1:0] op, logic [7:0] b, logic last, logic link,
                                   logic [7:0] cap);
            result_t r;
            bit      produce;
            int      chunk;
            int      tot;
            int      off;
            int      slot;
            int      len;
            r = '0;
            produce = 0;
            case (op)
                OP_WRITE: begin
                    if (frame_count < 4)
                        hdr[(3 - frame_count) * 8 +: 8] = b;
                    else if (frame_count - 4 < 256)
                        chunk_bytes[frame_count - 4] = b;
                    if (frame_count < 511)
                        frame_count++;
                    if (last) begin
                        produce = 1;
                        r.kind = KIND_STATUS;
                        chunk = frame_count - 4;
                        tot = int'(hdr[15:8]);
                        off = int'(hdr[7:0]);
                        if (!link || frame_count < 4 || hdr[31:24] != magic) begin
                            r.status = ST_IGNORED;
                        end else if (tot == 0 || tot > MAX_PACKET_BYTES || chunk == 0 ||
                                     off + chunk > tot) begin
                            asm_active = 0;
                            r.status = ST_BAD_LEN;
                        end else begin
                            // a new id restarts assembly from offset zero
                            if (!asm_active || asm_id != hdr[23:16]) begin
                                asm_active = 1;
                                asm_id = hdr[23:16];
                                asm_total = hdr[15:8];
                                asm_rcvd = 0;
                            end
                            if (asm_total != tot || off != asm_rcvd) begin
                                asm_active = 0;
                                r.status = ST_ORDER;
                            end else begin
                                for (int i = 0; i < chunk; i++)
                                    asm_bytes[(off + i) & 8'hFF] = chunk_bytes[i];
                                asm_rcvd += chunk;
                                if (asm_rcvd < asm_total) begin
                                    r.status = ST_CHUNK_OK;
                                end else begin
                                    asm_active = 0;
                                    r.plen = 8'(tot);
                                    if (fill >= QUEUE_DEPTH) begin
                                        r.status = ST_FULL_DROP;
                                    end else begin
                                        slot = (head + fill) % QUEUE_DEPTH;
                                        for (int i = 0; i < tot; i++)
                                            pkt_bytes[slot][i] = asm_bytes[i];
                                        pkt_len[slot] = tot;
                                        fill++;
                                        r.status = ST_QUEUED;
                                    end
                                end
                            end
                        end
                        frame_count = 0;
                    end
                end
                OP_READ: begin
                    produce = 1;
                    if (fill == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        len = pkt_len[head];
                        // capacity only matters on the first byte of a packet
                        if (rd_idx == 0 && len > cap) begin
                            pop_packet();
                            r.status = ST_OVERSIZE;
                            r.plen = 8'(len);
                        end else begin
                            r.kind = KIND_DATA;
                            r.status = ST_CHUNK_OK;
                            r.out_byte = pkt_bytes[head][rd_idx];
                            r.last = (rd_idx + 1 >= len);
                            r.plen = 8'(len);
                            if (r.last)
                                pop_packet();
                            else
                                rd_idx++;
                        end
                    end
                end
                OP_CLEAR: begin
                    fill = 0;
                    head = 0;
                    rd_idx = 0;
                    asm_active = 0;
                    asm_rcvd = 0;
                    frame_count = 0;
                end
                default: ;
            endcase
            if (produce) begin
                r.qcount = 4'(fill);
                pending_results.push_back(r);
            end
        endfunction

        function void field_check(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [23:0] d, logic last, logic kind);
            result_t want;
            if (pending_results.size() == 0) begin
                $error("unexpected result: tdata %h tlast %b tuser %b", d, last, kind);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            field_check("kind", 8'(want.kind), 8'(kind));
            field_check("status", 8'(want.status), 8'(d[2:0]));
            field_check("out_byte", want.out_byte, d[10:3]);
            field_check("byte_last", 8'(want.last), 8'(last));
            field_check("packet_length", want.plen, d[18:11]);
            field_check("queue_count", 8'(want.qcount), 8'(d[22:19]));
            if (want.kind == KIND_DATA)
                data_hits++;
            else
                status_hits[want.status]++;
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = 24'd0;
    logic        s_tlast = 1'b0;
    logic [1:0]  s_tuser = OP_NOP;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    bit            steady = 0;
    int            sent = 0;
    int            quiet = 0;
    packet_tracker sb = new();

    chunked_packet_reassembler uut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(negedge aclk)
        m_tready <= steady || ($urandom_range(0, 99) >= 29);

    always @(posedge aclk)
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tlast, m_tuser[0]);

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", quiet);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // one request on the input stream; called and returns at a falling edge
    task automatic send_req(logic [1:0] op, logic [7:0] b, logic last, logic link,
                            logic [7:0] cap);
        while (!steady && $urandom_range(0, 99) < 29) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = op;
        s_tdata = {7'd0, cap, link, b};
        s_tlast = last;
        do @(posedge aclk); while (!s_tready);
        sb.take_request(op, b, last, link, cap);
        if (op != OP_NOP)
            sent++;
        @(negedge aclk);
    endtask

    // header bytes first (magic, id, total, offset), then random chunk bytes
    task automatic send_frame(logic [31:0] header, int len, logic link);
        logic [7:0] b;
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 49) == 0)
                send_req(($urandom_range(0, 1)) ? OP_READ : OP_NOP, 8'($urandom), 1'($urandom),
                         1'($urandom), 8'hFF);
            b = (k < 4) ? header[31 - 8 * k -: 8] : 8'($urandom);
            send_req(OP_WRITE, b, k == len - 1, (k == len - 1) ? link : 1'($urandom),
                     8'($urandom));
        end
    endtask

    // well-formed chunk sequence for one packet, with occasional broken frames
    task automatic send_packet();
        int         total;
        int         off;
        int         span;
        int         n;
        int         len;
        int         fault;
        logic [7:0] id;
        logic [7:0] frame_id;
        logic [7:0] mg;
        logic [7:0] tot_b;
        logic [7:0] off_b;
        logic       link;
        id = 8'($urandom);
        if ($urandom_range(0, 29) == 0)
            total = ($urandom_range(0, 1)) ? MAX_PACKET_BYTES : $urandom_range(40, 254);
        else
            total = $urandom_range(1, 12);
        off = 0;
        while (off < total) begin
            span = (total > 40) ? 48 : 6;
            if (span > total - off)
                span = total - off;
            n = $urandom_range(1, span);
            mg = sb.magic;
            frame_id = id;
            tot_b = 8'(total);
            off_b = 8'(off);
            link = 1'b1;
            len = n + 4;
            fault = $urandom_range(0, 99);
            if (fault < 2)
                mg = sb.magic ^ 8'($urandom_range(1, 255));
            else if (fault < 4)
                link = 1'b0;
            else if (fault < 6)
                off_b = 8'(off + 1);
            else if (fault < 7)
                tot_b = 8'(total) ^ 8'($urandom_range(1, 255));
            else if (fault < 8)
                len = $urandom_range(0, 4);
            else if (fault < 9)
                frame_id = id ^ 8'($urandom_range(1, 255));
            else if (fault < 10)
                len = len + 1;
            send_frame({mg, frame_id, tot_b, off_b}, len, link);
            off += n;
        end
    endtask

    // reads the head packet, sometimes only part of it or with too small a capacity
    task automatic read_packet();
        int         len;
        int         n;
        logic [7:0] cap;
        len = sb.head_length();
        if (len > 0 && $urandom_range(0, 99) < 15)
            cap = 8'($urandom_range(0, len - 1));
        else
            cap = 8'($urandom_range(len, 255));
        n = (len == 0) ? 1 : len - sb.rd_idx;
        if ($urandom_range(0, 4) == 0)
            n = $urandom_range(1, n);
        repeat (n)
            send_req(OP_READ, 8'($urandom), 1'($urandom), 1'($urandom), cap);
    endtask

    task automatic write_magic(logic [7:0] v);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {REG_FRAME_MAGIC, 2'b00};
        pwdata = {24'd0, v};
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        sb.magic = v;
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // wait for every owed result, let the pipeline settle, then reprogram
    task automatic drain_and_set(logic [7:0] v);
        s_tvalid = 1'b0;
        while (sb.pending_results.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
        write_magic(v);
    endtask

    initial begin
        logic [7:0] magics [4];
        int         phase_end;
        int         pick;
        magics[0] = 8'hFF;
        magics[1] = 8'($urandom_range(1, 254));
        magics[2] = 8'h00;
        magics[3] = 8'($urandom_range(1, 254));
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: magic still at its reset value of zero
        send_req(OP_READ, 8'hFF, 1'b1, 1'b1, 8'hFF);
        send_req(OP_NOP, 8'h00, 1'b0, 1'b0, 8'h00);
        send_req(OP_CLEAR, 8'h5A, 1'b1, 1'b0, 8'hA5);
        send_frame(32'h00000000, 1, 1'b1);
        send_frame({8'h00, 8'h02, 8'h02, 8'h01}, 5, 1'b1);
        send_frame({8'h00, 8'h02, 8'h02, 8'h00}, 6, 1'b1);
        send_req(OP_READ, 8'h00, 1'b0, 1'b0, 8'h01);
        send_frame({8'h00, 8'h03, 8'h05, 8'h00}, 4, 1'b1);
        send_frame({8'h00, 8'h04, 8'h01, 8'h00}, 5, 1'b0);

        for (int p = 0; p < 4; p++) begin
            drain_and_set(magics[p]);
            phase_end = sent + ITEMS_PER_PHASE;
            steady = (p == 1);
            while (sent < phase_end) begin
                if (steady && sent > phase_end - ITEMS_PER_PHASE + 150)
                    steady = 0;
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    send_packet();
                end else if (pick < 78) begin
                    read_packet();
                end else if (pick < 83) begin
                    // clear, sometimes cutting a frame short
                    if ($urandom_range(0, 1))
                        repeat ($urandom_range(1, 6))
                            send_req(OP_WRITE, 8'($urandom), 1'b0, 1'($urandom), 8'($urandom));
                    send_req(OP_CLEAR, 8'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
                end else if (pick < 87) begin
                    send_req(OP_NOP, 8'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
                end else if (pick < 99) begin
                    send_frame({($urandom_range(0, 1)) ? sb.magic : 8'($urandom), 24'($urandom)},
                               $urandom_range(0, 10), $urandom_range(0, 3) != 0);
                end else begin
                    // oversized frame that sometimes runs the byte counter up to its limit
                    send_frame({sb.magic, 8'($urandom), 8'($urandom), 8'h00},
                               $urandom_range(257, 520), 1'b1);
                end
            end
        end

        s_tvalid = 1'b0;
        steady = 0;
        while (sb.pending_results.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("run covered %0d requests under four frame magic settings, %0d bytes read",
                 sent, sb.data_hits);
        $display("status: ok %0d queued %0d full %0d ignored %0d badlen %0d order %0d",
                 sb.status_hits[ST_CHUNK_OK], sb.status_hits[ST_QUEUED],
                 sb.status_hits[ST_FULL_DROP], sb.status_hits[ST_IGNORED],
                 sb.status_hits[ST_BAD_LEN], sb.status_hits[ST_ORDER]);
        $display("        empty %0d oversize %0d",
                 sb.status_hits[ST_EMPTY], sb.status_hits[ST_OVERSIZE]);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
